FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lbe_pkg.sv
`default_nettype none

package lbe_pkg;

   localparam int BPM_LOW  = 1;
   localparam int BPM_HIGH = 30;

   localparam int NOW_W       = 32;
   localparam int LVL_W       = 16;
   localparam int RPT_W       = 10;
   localparam int BPM_W       = 5;
   localparam int UNIT_W      = 4;
   localparam int DEPTH_W     = 16;
   localparam int FLOOR_W     = 7;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam int PHASE_W  = 16;   // phase numerator, below 60000
   localparam int P_W      = 22;   // phase times total units
   localparam int NUM_W    = 20;   // span-relative position
   localparam int DEN_W    = 20;   // span length on the 60000 scale
   localparam int RECIP_W  = 25;
   localparam int Q17_W    = 17;   // value on a scale where 65536 is 1.0
   localparam int BASE_W   = 11;

   localparam int PHASE_STAGES = 7;
   localparam int DIV_STAGES   = 4;
   localparam int SHAPE_STAGES = 4;
   localparam int STAGES       = PHASE_STAGES + DIV_STAGES + SHAPE_STAGES + 1;

   localparam logic [15:0] PHASE_DEN = 16'd60000;
   // floor(2^47 / 60000): quotient estimate of a 32-bit word, low by at most one
   localparam logic [31:0] PHASE_RECIP_WIDE  = 32'd2345624805;
   localparam int          PHASE_SHIFT_WIDE  = 47;
   // floor(2^32 / 60000) for the narrow second reduction
   localparam logic [16:0] PHASE_RECIP_NARROW = 17'd71582;
   localparam int          PHASE_SHIFT_NARROW = 32;
   localparam int          SPAN_SHIFT         = 24;

   localparam logic [Q17_W-1:0] ONE_Q16   = 17'h10000;
   localparam logic [17:0]      SMOOTH_K3 = 18'd196608;

   localparam logic [LVL_W-1:0] BREATH_OFF = 16'h8000;
   localparam logic [LVL_W-1:0] LEVEL_MAX  = 16'hFFFF;
   localparam int               REPAINT_CAP = 66;
   localparam int               REPAINT_OFF = 1000;

   typedef struct packed {
      logic                 enable;
      logic [BPM_W-1:0]     bpm;
      logic [DEPTH_W-1:0]   depth;
      logic [UNIT_W-1:0]    inhale;
      logic [UNIT_W-1:0]    hold;
      logic [UNIT_W-1:0]    exhale;
      logic [FLOOR_W-1:0]   floor_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      enable:   1'b1,
      bpm:      5'd3,
      depth:    16'd32768,
      inhale:   4'd5,
      hold:     4'd6,
      exhale:   4'd7,
      floor_ms: 7'd16
   };

   typedef enum logic [2:0] {
      SPAN_INHALE = 3'b001,
      SPAN_FULL   = 3'b010,
      SPAN_EXHALE = 3'b100
   } span_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_BPM    = 3'd1,
      CSR_DEPTH  = 3'd2,
      CSR_INHALE = 3'd3,
      CSR_HOLD   = 3'd4,
      CSR_EXHALE = 3'd5,
      CSR_FLOOR  = 3'd6
   } csr_index_type;

   function automatic logic [BPM_W-1:0] bound_rate(input logic [BPM_W-1:0] v);
      logic [BPM_W-1:0] r;
      if (v < BPM_W'(BPM_LOW)) begin
         r = BPM_W'(BPM_LOW);
      end else if (v > BPM_W'(BPM_HIGH)) begin
         r = BPM_W'(BPM_HIGH);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [DEN_W-1:0] span_den(input logic [UNIT_W-1:0] unit);
      return DEN_W'(unit) * DEN_W'(PHASE_DEN);
   endfunction

   // floor(2^40 / (unit * 60000))
   function automatic logic [RECIP_W-1:0] span_recip(input logic [UNIT_W-1:0] unit);
      logic [RECIP_W-1:0] r;
      case (unit)
         4'd1:    r = 25'd18325193;
         4'd2:    r = 25'd9162596;
         4'd3:    r = 25'd6108397;
         4'd4:    r = 25'd4581298;
         4'd5:    r = 25'd3665038;
         4'd6:    r = 25'd3054198;
         4'd7:    r = 25'd2617884;
         4'd8:    r = 25'd2290649;
         4'd9:    r = 25'd2036132;
         4'd10:   r = 25'd1832519;
         4'd11:   r = 25'd1665926;
         4'd12:   r = 25'd1527099;
         4'd13:   r = 25'd1409630;
         4'd14:   r = 25'd1308942;
         4'd15:   r = 25'd1221679;
         default: r = '0;
      endcase
      return r;
   endfunction

   // floor(floor(60000 / bpm) / 56), with a zero rate read as one
   function automatic logic [BASE_W-1:0] repaint_base(input logic [BPM_W-1:0] bpm);
      logic [BASE_W-1:0] r;
      case (bpm)
         5'd0:    r = 11'd1071;
         5'd1:    r = 11'd1071;
         5'd2:    r = 11'd535;
         5'd3:    r = 11'd357;
         5'd4:    r = 11'd267;
         5'd5:    r = 11'd214;
         5'd6:    r = 11'd178;
         5'd7:    r = 11'd153;
         5'd8:    r = 11'd133;
         5'd9:    r = 11'd119;
         5'd10:   r = 11'd107;
         5'd11:   r = 11'd97;
         5'd12:   r = 11'd89;
         5'd13:   r = 11'd82;
         5'd14:   r = 11'd76;
         5'd15:   r = 11'd71;
         5'd16:   r = 11'd66;
         5'd17:   r = 11'd63;
         5'd18:   r = 11'd59;
         5'd19:   r = 11'd56;
         5'd20:   r = 11'd53;
         5'd21:   r = 11'd51;
         5'd22:   r = 11'd48;
         5'd23:   r = 11'd46;
         5'd24:   r = 11'd44;
         5'd25:   r = 11'd42;
         5'd26:   r = 11'd41;
         5'd27:   r = 11'd39;
         5'd28:   r = 11'd38;
         5'd29:   r = 11'd36;
         5'd30:   r = 11'd35;
         5'd31:   r = 11'd34;
         default: r = 11'd1071;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lbe_phase.sv
`default_nettype none

module lbe_phase (
   input  logic                               clock,
   input  logic [lbe_pkg::PHASE_STAGES-1:0]   load,
   input  logic [lbe_pkg::NOW_W-1:0]          now_ms,
   input  lbe_pkg::cfg_type                   cfg,
   output logic [lbe_pkg::P_W-1:0]            pos
);
   import lbe_pkg::*;

   localparam int QUO_W = 17;
   localparam int Y_W   = 21;
   localparam int YQ_W  = 5;

   logic [63:0]          a_prod;
   logic [NOW_W-1:0]     a_now_in, a_now_ff;
   logic [QUO_W-1:0]     a_quo_in, a_quo_ff;
   logic [NOW_W-1:0]     b_now_in, b_now_ff;
   logic [NOW_W-1:0]     b_sub_in, b_sub_ff;
   logic [Q17_W-1:0]     c_diff;
   logic [PHASE_W-1:0]   c_rem_in, c_rem_ff;
   logic [Y_W-1:0]       d_y_in, d_y_ff;
   logic [36:0]          e_prod;
   logic [YQ_W-1:0]      e_quo_in, e_quo_ff;
   logic [Y_W-1:0]       e_y_in, e_y_ff;
   logic [Y_W-1:0]       f_sub;
   logic [Q17_W-1:0]     f_diff;
   logic [PHASE_W-1:0]   f_m_in, f_m_ff;
   logic [5:0]           g_total;
   logic [P_W-1:0]       g_pos_in, g_pos_ff;

   // now mod 60000 by reciprocal estimate and one correction
   assign a_prod   = 64'(now_ms) * 64'(PHASE_RECIP_WIDE);
   assign a_now_in = now_ms;
   assign a_quo_in = a_prod[PHASE_SHIFT_WIDE +: QUO_W];

   assign b_now_in = a_now_ff;
   assign b_sub_in = {15'd0, a_quo_ff} * {16'd0, PHASE_DEN};

   assign c_diff   = Q17_W'(b_now_ff - b_sub_ff);
   assign c_rem_in = (c_diff >= Q17_W'(PHASE_DEN)) ? PHASE_W'(c_diff - Q17_W'(PHASE_DEN))
                                                   : c_diff[PHASE_W-1:0];

   assign d_y_in = {5'd0, c_rem_ff} * {16'd0, cfg.bpm};

   // second reduction of the rate-scaled remainder
   assign e_prod   = {16'd0, d_y_ff} * {20'd0, PHASE_RECIP_NARROW};
   assign e_quo_in = e_prod[PHASE_SHIFT_NARROW +: YQ_W];
   assign e_y_in   = d_y_ff;

   assign f_sub  = {16'd0, e_quo_ff} * {5'd0, PHASE_DEN};
   assign f_diff = Q17_W'(e_y_ff - f_sub);
   assign f_m_in = (f_diff >= Q17_W'(PHASE_DEN)) ? PHASE_W'(f_diff - Q17_W'(PHASE_DEN))
                                                 : f_diff[PHASE_W-1:0];

   assign g_total  = {2'd0, cfg.inhale} + {2'd0, cfg.hold} + {2'd0, cfg.exhale};
   assign g_pos_in = {6'd0, f_m_ff} * {16'd0, g_total};

   always_ff @(posedge clock) begin
      if (load[0]) begin
         a_now_ff <= a_now_in;
         a_quo_ff <= a_quo_in;
      end
      if (load[1]) begin
         b_now_ff <= b_now_in;
         b_sub_ff <= b_sub_in;
      end
      if (load[2]) begin
         c_rem_ff <= c_rem_in;
      end
      if (load[3]) begin
         d_y_ff <= d_y_in;
      end
      if (load[4]) begin
         e_quo_ff <= e_quo_in;
         e_y_ff   <= e_y_in;
      end
      if (load[5]) begin
         f_m_ff <= f_m_in;
      end
      if (load[6]) begin
         g_pos_ff <= g_pos_in;
      end
   end

   assign pos = g_pos_ff;

endmodule

`default_nettype wire

FILE: rtl/lbe_span_div.sv
`default_nettype none

module lbe_span_div (
   input  logic                             clock,
   input  logic [lbe_pkg::DIV_STAGES-1:0]   load,
   input  logic [lbe_pkg::P_W-1:0]          pos,
   input  lbe_pkg::cfg_type                 cfg,
   output lbe_pkg::span_type                span,
   output logic [lbe_pkg::LVL_W-1:0]        t_q16
);
   import lbe_pkg::*;

   localparam int IP_W  = NUM_W + RECIP_W;
   localparam int CHK_W = NUM_W + LVL_W;

   logic [DEN_W-1:0]    h_in_end;
   logic [DEN_W:0]      h_hold_end;
   span_type            h_span_in, h_span_ff;
   logic [NUM_W-1:0]    h_num_in, h_num_ff;
   logic [UNIT_W-1:0]   h_unit_in, h_unit_ff;

   logic [IP_W-1:0]     i_prod;
   logic [LVL_W-1:0]    i_est_in, i_est_ff;
   span_type            i_span_ff;
   logic [NUM_W-1:0]    i_num_ff;
   logic [UNIT_W-1:0]   i_unit_ff;

   logic [CHK_W-1:0]    j_chk_in, j_chk_ff;
   logic [LVL_W-1:0]    j_est_ff;
   span_type            j_span_ff;
   logic [NUM_W-1:0]    j_num_ff;
   logic [UNIT_W-1:0]   j_unit_ff;

   logic [CHK_W-1:0]    k_rem;
   logic [LVL_W-1:0]    k_t_in, k_t_ff;
   span_type            k_span_ff;

   assign h_in_end   = span_den(cfg.inhale);
   assign h_hold_end = {1'b0, span_den(cfg.inhale)} + {1'b0, span_den(cfg.hold)};

   // pick the span and the position inside it
   always_comb begin
      if (pos < P_W'(h_in_end)) begin
         h_span_in = SPAN_INHALE;
         h_num_in  = NUM_W'(pos);
         h_unit_in = cfg.inhale;
      end else if ((pos < P_W'(h_hold_end)) || (cfg.exhale == '0)) begin
         h_span_in = SPAN_FULL;
         h_num_in  = '0;
         h_unit_in = '0;
      end else begin
         h_span_in = SPAN_EXHALE;
         h_num_in  = NUM_W'(pos - P_W'(h_hold_end));
         h_unit_in = cfg.exhale;
      end
   end

   // quotient estimate, low by at most one
   assign i_prod   = IP_W'(h_num_ff) * IP_W'(span_recip(h_unit_ff));
   assign i_est_in = i_prod[SPAN_SHIFT +: LVL_W];

   assign j_chk_in = CHK_W'(i_est_ff) * CHK_W'(span_den(i_unit_ff));

   assign k_rem  = {j_num_ff, {LVL_W{1'b0}}} - j_chk_ff;
   assign k_t_in = (k_rem >= CHK_W'(span_den(j_unit_ff))) ? j_est_ff + LVL_W'(1) : j_est_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         h_span_ff <= h_span_in;
         h_num_ff  <= h_num_in;
         h_unit_ff <= h_unit_in;
      end
      if (load[1]) begin
         i_est_ff  <= i_est_in;
         i_span_ff <= h_span_ff;
         i_num_ff  <= h_num_ff;
         i_unit_ff <= h_unit_ff;
      end
      if (load[2]) begin
         j_chk_ff  <= j_chk_in;
         j_est_ff  <= i_est_ff;
         j_span_ff <= i_span_ff;
         j_num_ff  <= i_num_ff;
         j_unit_ff <= i_unit_ff;
      end
      if (load[3]) begin
         k_t_ff    <= k_t_in;
         k_span_ff <= j_span_ff;
      end
   end

   assign span  = k_span_ff;
   assign t_q16 = k_t_ff;

endmodule

`default_nettype wire

FILE: rtl/lbe_shape.sv
`default_nettype none

module lbe_shape (
   input  logic                               clock,
   input  logic [lbe_pkg::SHAPE_STAGES-1:0]   load,
   input  lbe_pkg::span_type                  span,
   input  logic [lbe_pkg::LVL_W-1:0]          t_q16,
   input  logic [lbe_pkg::DEPTH_W-1:0]        depth,
   output logic [lbe_pkg::Q17_W-1:0]          level,
   output logic [lbe_pkg::Q17_W-1:0]          drop
);
   import lbe_pkg::*;

   localparam int SQ_W = 2 * LVL_W;
   localparam int SP_W = SQ_W + 18;
   localparam int DP_W = DEPTH_W + Q17_W;

   logic [SQ_W-1:0]     l_sq_in, l_sq_ff;
   logic [17:0]         l_k_in, l_k_ff;
   span_type            l_span_ff;

   logic [SP_W-1:0]     m_prod;
   logic [Q17_W-1:0]    m_s_in, m_s_ff;
   span_type            m_span_ff;

   logic [Q17_W-1:0]    n_level_in, n_level_ff;

   logic [Q17_W-1:0]    o_rise;
   logic [DP_W-1:0]     o_prod;
   logic [Q17_W-1:0]    o_drop_in, o_drop_ff;
   logic [Q17_W-1:0]    o_level_ff;

   // smoothstep t*t*(3 - 2t)
   assign l_sq_in = SQ_W'(t_q16) * SQ_W'(t_q16);
   assign l_k_in  = SMOOTH_K3 - {1'b0, t_q16, 1'b0};

   assign m_prod = SP_W'(l_sq_ff) * SP_W'(l_k_ff);
   assign m_s_in = m_prod[SQ_W +: Q17_W];

   always_comb begin
      case (m_span_ff)
         SPAN_INHALE: n_level_in = m_s_ff;
         SPAN_FULL:   n_level_in = ONE_Q16;
         SPAN_EXHALE: n_level_in = (m_s_ff >= ONE_Q16) ? '0 : ONE_Q16 - m_s_ff;
         default:     n_level_in = ONE_Q16;
      endcase
   end

   assign o_rise    = ONE_Q16 - n_level_ff;
   assign o_prod    = DP_W'(depth) * DP_W'(o_rise);
   assign o_drop_in = o_prod[LVL_W +: Q17_W];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         l_sq_ff   <= l_sq_in;
         l_k_ff    <= l_k_in;
         l_span_ff <= span;
      end
      if (load[1]) begin
         m_s_ff    <= m_s_in;
         m_span_ff <= l_span_ff;
      end
      if (load[2]) begin
         n_level_ff <= n_level_in;
      end
      if (load[3]) begin
         o_drop_ff  <= o_drop_in;
         o_level_ff <= n_level_ff;
      end
   end

   assign level = o_level_ff;
   assign drop  = o_drop_ff;

endmodule

`default_nettype wire

FILE: rtl/led_breath_envelope_unit.sv
// One req word per cycle is taken while rsp_ready is high or a stage holds a bubble.
// The pipeline depth comes from the chain of reciprocal multiplies (two phase reductions,
// span division with a remainder check, smoothstep and depth scaling).
// Reset: synchronous, active high; empties the pipeline and loads the register defaults.
// Output stalls back up stage by stage, so the pipeline fills before req_ready drops.
`default_nettype none
`include "assert_macros.svh"

module led_breath_envelope_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lbe_pkg::NOW_W-1:0]         req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lbe_pkg::LVL_W-1:0]         rsp_breath_level,
   output logic [lbe_pkg::LVL_W-1:0]         rsp_brightness,
   output logic [lbe_pkg::RPT_W-1:0]         rsp_repaint_ms,
   input  logic                              csr_write_en,
   input  logic [lbe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lbe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lbe_pkg::*;

   localparam int DIV_BASE   = PHASE_STAGES;
   localparam int SHAPE_BASE = PHASE_STAGES + DIV_STAGES;
   localparam int OUT_STAGE  = STAGES - 1;
   localparam logic [STAGES-1:0] STAGE_ONES = {STAGES{1'b1}};

   cfg_type              cfg_in, cfg_ff;
   logic [STAGES-1:0]    vld_in, vld_ff;
   logic [STAGES-1:0]    load;

   logic [P_W-1:0]       pos;
   span_type             span;
   logic [LVL_W-1:0]     t_q16;
   logic [Q17_W-1:0]     level;
   logic [Q17_W-1:0]     drop;

   logic [Q17_W-1:0]     bright;
   logic [BASE_W-1:0]    rpt_base;
   logic [BASE_W-1:0]    rpt_lift;
   logic [LVL_W-1:0]     rsp_breath_in, rsp_breath_ff;
   logic [LVL_W-1:0]     rsp_bright_in, rsp_bright_ff;
   logic [RPT_W-1:0]     rsp_repaint_in, rsp_repaint_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE: cfg_in.enable   = csr_wdata[0];
            CSR_BPM:    cfg_in.bpm      = bound_rate(csr_wdata[BPM_W-1:0]);
            CSR_DEPTH:  cfg_in.depth    = csr_wdata[DEPTH_W-1:0];
            CSR_INHALE: cfg_in.inhale   = csr_wdata[UNIT_W-1:0];
            CSR_HOLD:   cfg_in.hold     = csr_wdata[UNIT_W-1:0];
            CSR_EXHALE: cfg_in.exhale   = csr_wdata[UNIT_W-1:0];
            CSR_FLOOR:  cfg_in.floor_ms = csr_wdata[FLOOR_W-1:0];
            default: ;
         endcase
      end
   end

   // a stage loads when the output drains or a bubble sits at or after it
   always_comb begin
      for (int i = 0; i < STAGES; i++) begin
         load[i] = rsp_ready || ((vld_ff >> i) != (STAGE_ONES >> i));
      end
   end

   always_comb begin
      vld_in[0] = load[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = load[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
         vld_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         vld_ff <= vld_in;
      end
   end

   lbe_phase u_phase (
      .clock  (clock),
      .load   (load[PHASE_STAGES-1:0]),
      .now_ms (req_now_ms),
      .cfg    (cfg_ff),
      .pos    (pos)
   );

   lbe_span_div u_span_div (
      .clock (clock),
      .load  (load[DIV_BASE +: DIV_STAGES]),
      .pos   (pos),
      .cfg   (cfg_ff),
      .span  (span),
      .t_q16 (t_q16)
   );

   lbe_shape u_shape (
      .clock (clock),
      .load  (load[SHAPE_BASE +: SHAPE_STAGES]),
      .span  (span),
      .t_q16 (t_q16),
      .depth (cfg_ff.depth),
      .level (level),
      .drop  (drop)
   );

   assign bright   = ONE_Q16 - drop;
   assign rpt_base = repaint_base(cfg_ff.bpm);
   assign rpt_lift = (rpt_base < BASE_W'(cfg_ff.floor_ms)) ? BASE_W'(cfg_ff.floor_ms) : rpt_base;

   always_comb begin
      if (!cfg_ff.enable) begin
         rsp_breath_in  = BREATH_OFF;
         rsp_bright_in  = LEVEL_MAX;
         rsp_repaint_in = RPT_W'(REPAINT_OFF);
      end else begin
         rsp_breath_in  = (level > Q17_W'(LEVEL_MAX)) ? LEVEL_MAX : level[LVL_W-1:0];
         rsp_bright_in  = (bright > Q17_W'(LEVEL_MAX)) ? LEVEL_MAX : bright[LVL_W-1:0];
         rsp_repaint_in = (rpt_lift > BASE_W'(REPAINT_CAP)) ? RPT_W'(REPAINT_CAP)
                                                             : RPT_W'(rpt_lift);
      end
   end

   always_ff @(posedge clock) begin
      if (load[OUT_STAGE]) begin
         rsp_breath_ff  <= rsp_breath_in;
         rsp_bright_ff  <= rsp_bright_in;
         rsp_repaint_ff <= rsp_repaint_in;
      end
   end

   assign req_ready        = load[0];
   assign rsp_valid        = vld_ff[OUT_STAGE];
   assign rsp_breath_level = rsp_breath_ff;
   assign rsp_brightness   = rsp_bright_ff;
   assign rsp_repaint_ms   = rsp_repaint_ff;

   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, vld_ff[0], "accepted word did not enter the first stage")
   `ASSERT_IMP(a_full_blocks, clock, reset, (&vld_ff) && !rsp_ready, !req_ready, "word taken while pipeline full and stalled")
   `ASSERT_IMP(a_bpm_range, clock, reset, 1'b1, (cfg_ff.bpm >= BPM_W'(BPM_LOW)) && (cfg_ff.bpm <= BPM_W'(BPM_HIGH)), "bpm register outside its limits")
   `ASSERT_IMP(a_repaint_range, clock, reset, rsp_valid, (rsp_repaint_ms <= RPT_W'(REPAINT_CAP)) || (rsp_repaint_ms == RPT_W'(REPAINT_OFF)), "repaint interval out of range")

endmodule

`default_nettype wire
